// ===== rtl/l4lb_pkg.sv =====
// shared types, constants and helpers of the l4 hash load balancer
package l4lb_pkg;

  localparam int unsigned BACKEND_COUNT_DEF = 4;
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [31:0] GOLDEN_MUL = 32'h9e37_79b1;
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [16:0] ETH_HDR_LEN = 17'd14;
  localparam logic [16:0] IP_HDR_MIN = 17'd20;
  localparam logic [16:0] TCP_HDR_LEN = 17'd20;

  typedef enum logic {
    OP_PACKET      = 1'b0,
    OP_TABLE_WRITE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    VERDICT_PASS     = 2'd0,
    VERDICT_REWRITE  = 2'd1,
    VERDICT_REDIRECT = 2'd2
  } verdict_e;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_TARGET_ADDRESS = 1'b0,
    CFG_PEER_INTERFACE = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic        op;
    logic [15:0] frame_length;
    logic [15:0] ethertype;
    logic [3:0]  header_words;
    logic [7:0]  protocol;
    logic [31:0] src_addr;
    logic [31:0] address;
    logic [15:0] ip_checksum;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [1:0]  entry_index;
    logic [47:0] entry_mac;
  } in_t;

  typedef struct packed {
    verdict_e    verdict;
    logic [1:0]  backend_index;
    logic [31:0] new_address;
    logic [15:0] new_checksum;
    logic [47:0] new_mac;
  } out_t;

  // what a transaction still needs after the header checks
  typedef struct packed {
    logic        op;
    logic        ok;
    logic [31:0] address;
    logic [15:0] ip_checksum;
    logic [1:0]  entry_index;
    logic [47:0] entry_mac;
  } carry_t;

  // per-stage load enables
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
    logic s6;
    logic s7;
  } pipe_en_t;

  function automatic int unsigned idx_bits(input int unsigned n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

// ===== rtl/l4_hash_load_balancer_rewrite_top.sv =====
// top level of the l4 hash load balancer with destination rewrite
//
// input channel: in_valid_i / in_stall_o / in_data_i. op selects a packet
// header (one result) or a backend table write (no result).
// output channel: out_valid_o / out_stall_i / out_data_o with verdict,
// backend slot, new destination address, updated checksum and backend mac.
// config port: cfg_we_i, cfg_index_i, cfg_wdata_i (target address, peer
// interface); write only while no transaction is in flight.
// seven-stage pipeline: input register, hash multiply, reciprocal multiply,
// quotient multiply, remainder correction, table read, checksum and result
// register. one transaction per cycle is accepted when the receiver
// keeps up.
// table writes commit in the table-read stage, in order with packet reads,
// so a packet sees every earlier write.
// reset clears the table valid bits (all slots read as zero), both config
// registers and all stage valids.
// when the receiver stalls, the result holds and earlier stages keep
// filling their empty slots; input stall rises only once every stage is full.
module l4_hash_load_balancer_rewrite_top #(
  parameter int unsigned BACKEND_COUNT = l4lb_pkg::BACKEND_COUNT_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [l4lb_pkg::CFG_INDEX_W-1:0]   cfg_index_i,
  input  logic [l4lb_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  l4lb_pkg::in_t                      in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output l4lb_pkg::out_t                     out_data_o
);

  localparam int unsigned KW = l4lb_pkg::idx_bits(BACKEND_COUNT);

  logic [31:0]        target_q, peer_q;
  logic [7:1]         valid_q, rdy;
  l4lb_pkg::pipe_en_t en;
  l4lb_pkg::in_t      item1_q;
  l4lb_pkg::carry_t   carry5, carry6;
  logic [KW-1:0]      key5, key6;
  logic [31:0]        rd_ip;
  logic [47:0]        rd_mac;

  always_comb begin
    rdy[7] = !valid_q[7] || !out_stall_i;
    for (int k = 6; k >= 1; k--) begin
      rdy[k] = !valid_q[k] || rdy[k+1];
    end
    en.s1 = rdy[1];
    en.s2 = rdy[2];
    en.s3 = rdy[3];
    en.s4 = rdy[4];
    en.s5 = rdy[5];
    en.s6 = rdy[6];
    en.s7 = rdy[7];
  end

  assign in_stall_o  = !rdy[1];
  assign out_valid_o = valid_q[7];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      target_q <= '0;
      peer_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (l4lb_pkg::cfg_reg_e'(cfg_index_i))
          l4lb_pkg::CFG_TARGET_ADDRESS: target_q <= cfg_wdata_i;
          l4lb_pkg::CFG_PEER_INTERFACE: peer_q   <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (rdy[1]) valid_q[1] <= in_valid_i;
      for (int k = 2; k <= 6; k++) begin
        if (rdy[k]) valid_q[k] <= valid_q[k-1];
      end
      // table writes leave the pipe after the table stage
      if (rdy[7]) valid_q[7] <= valid_q[6] && (carry6.op == l4lb_pkg::OP_PACKET);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en.s1) begin
      item1_q <= in_data_i;
    end
  end

  l4lb_hash #(
    .BACKEND_COUNT(BACKEND_COUNT)
  ) u_hash (
    .clk_i   (clk_i),
    .en_i    (en),
    .item_i  (item1_q),
    .target_i(target_q),
    .carry_o (carry5),
    .key_o   (key5)
  );

  l4lb_table #(
    .BACKEND_COUNT(BACKEND_COUNT)
  ) u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(valid_q[5]),
    .carry_i(carry5),
    .key_i  (key5),
    .carry_o(carry6),
    .key_o  (key6),
    .ip_o   (rd_ip),
    .mac_o  (rd_mac)
  );

  l4lb_rewrite #(
    .BACKEND_COUNT(BACKEND_COUNT)
  ) u_rewrite (
    .clk_i     (clk_i),
    .en_i      (en),
    .peer_set_i(peer_q != 32'd0),
    .carry_i   (carry6),
    .key_i     (key6),
    .ip_i      (rd_ip),
    .mac_i     (rd_mac),
    .out_o     (out_data_o)
  );

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> ((&valid_q) && out_stall_i))
    else $error("input stalled with a free stage");

  a_key_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[5] |-> (32'(key5) < 32'(BACKEND_COUNT)))
    else $error("backend slot out of range");

  a_pass_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.verdict == l4lb_pkg::VERDICT_PASS))
      |-> ((out_data_o.new_mac == 48'd0) && (out_data_o.backend_index == 2'd0)))
    else $error("unchanged packet carries backend data");

  a_redirect_needs_peer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.verdict == l4lb_pkg::VERDICT_REDIRECT))
      |-> (peer_q != 32'd0))
    else $error("redirect without peer interface");

endmodule

// ===== rtl/l4lb_hash.sv =====
// header checks, golden-ratio hash and reciprocal modulo, stages two to five
module l4lb_hash #(
  parameter int unsigned BACKEND_COUNT = l4lb_pkg::BACKEND_COUNT_DEF
) (
  input  logic                                           clk_i,
  input  l4lb_pkg::pipe_en_t                             en_i,
  input  l4lb_pkg::in_t                                  item_i,
  input  logic [31:0]                                    target_i,
  output l4lb_pkg::carry_t                               carry_o,
  output logic [l4lb_pkg::idx_bits(BACKEND_COUNT)-1:0]   key_o
);

  localparam int unsigned KW = l4lb_pkg::idx_bits(BACKEND_COUNT);
  localparam logic [32:0] RECIP = 33'((65'd1 << 32) / BACKEND_COUNT);
  localparam logic [31:0] COUNT_W = 32'(BACKEND_COUNT);

  l4lb_pkg::carry_t carry2_d, carry2_q, carry3_q, carry4_q, carry5_q;
  logic [31:0]      h2_d, h2_q, h3_q, h4_q;
  logic [31:0]      q3_d, q3_q, qc4_d, qc4_q;
  logic [16:0]      flen, tcp_min;
  logic             ok;
  logic [64:0]      prod;
  logic [31:0]      rem, rem_adj;
  logic [KW-1:0]    key5_d, key5_q;

  always_comb begin
    flen    = {1'b0, item_i.frame_length};
    tcp_min = l4lb_pkg::ETH_HDR_LEN + {11'b0, item_i.header_words, 2'b00}
            + l4lb_pkg::TCP_HDR_LEN;
    ok = (flen >= l4lb_pkg::ETH_HDR_LEN + l4lb_pkg::IP_HDR_MIN)
      && (item_i.ethertype == l4lb_pkg::ETHERTYPE_IPV4)
      && !((target_i != 32'd0) && (item_i.address != target_i))
      && (item_i.protocol == l4lb_pkg::PROTO_TCP)
      && (flen >= tcp_min);

    carry2_d.op          = item_i.op;
    carry2_d.ok          = ok;
    carry2_d.address     = item_i.address;
    carry2_d.ip_checksum = item_i.ip_checksum;
    carry2_d.entry_index = item_i.entry_index;
    carry2_d.entry_mac   = item_i.entry_mac;

    h2_d = (item_i.src_addr ^ item_i.address ^ {item_i.src_port, item_i.dst_port})
         * l4lb_pkg::GOLDEN_MUL;

    // quotient estimate, at most one short
    prod = 65'(h2_q) * 65'(RECIP);
    q3_d = prod[63:32];

    qc4_d = q3_q * COUNT_W;

    rem     = h4_q - qc4_q;
    rem_adj = (rem >= COUNT_W) ? rem - COUNT_W : rem;
    key5_d  = rem_adj[KW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      carry2_q <= carry2_d;
      h2_q     <= h2_d;
    end
    if (en_i.s3) begin
      carry3_q <= carry2_q;
      h3_q     <= h2_q;
      q3_q     <= q3_d;
    end
    if (en_i.s4) begin
      carry4_q <= carry3_q;
      h4_q     <= h3_q;
      qc4_q    <= qc4_d;
    end
    if (en_i.s5) begin
      carry5_q <= carry4_q;
      key5_q   <= key5_d;
    end
  end

  assign carry_o = carry5_q;
  assign key_o   = key5_q;

endmodule

// ===== rtl/l4lb_table.sv =====
// backend table memory, written and read in stage six
module l4lb_table #(
  parameter int unsigned BACKEND_COUNT = l4lb_pkg::BACKEND_COUNT_DEF
) (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  l4lb_pkg::pipe_en_t                             en_i,
  input  logic                                           valid_i,
  input  l4lb_pkg::carry_t                               carry_i,
  input  logic [l4lb_pkg::idx_bits(BACKEND_COUNT)-1:0]   key_i,
  output l4lb_pkg::carry_t                               carry_o,
  output logic [l4lb_pkg::idx_bits(BACKEND_COUNT)-1:0]   key_o,
  output logic [31:0]                                    ip_o,
  output logic [47:0]                                    mac_o
);

  localparam int unsigned KW = l4lb_pkg::idx_bits(BACKEND_COUNT);
  localparam logic [8:0] COUNT_9 = 9'(BACKEND_COUNT);

  logic [79:0]              mem [BACKEND_COUNT];
  logic [BACKEND_COUNT-1:0] vld_q;
  logic [79:0]              rd_q;
  logic                     rd_vld_q;
  logic [8:0]               slot;
  logic [KW-1:0]            waddr;
  logic                     we;
  l4lb_pkg::carry_t         carry6_q;
  logic [KW-1:0]            key6_q;

  always_comb begin
    slot  = 9'(carry_i.entry_index);
    waddr = slot[KW-1:0];
    we    = en_i.s6 && valid_i && (carry_i.op == l4lb_pkg::OP_TABLE_WRITE)
         && (slot < COUNT_9);
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= {carry_i.address, carry_i.entry_mac};
    end
    if (en_i.s6) begin
      rd_q     <= mem[key_i];
      carry6_q <= carry_i;
      key6_q   <= key_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (we) begin
        vld_q[waddr] <= 1'b1;
      end
      if (en_i.s6) begin
        rd_vld_q <= vld_q[key_i];
      end
    end
  end

  // an entry never written reads as zero
  assign ip_o    = rd_vld_q ? rd_q[79:48] : 32'd0;
  assign mac_o   = rd_vld_q ? rd_q[47:0] : 48'd0;
  assign carry_o = carry6_q;
  assign key_o   = key6_q;

endmodule

// ===== rtl/l4lb_rewrite.sv =====
// checksum update and result register, stage seven
module l4lb_rewrite #(
  parameter int unsigned BACKEND_COUNT = l4lb_pkg::BACKEND_COUNT_DEF
) (
  input  logic                                           clk_i,
  input  l4lb_pkg::pipe_en_t                             en_i,
  input  logic                                           peer_set_i,
  input  l4lb_pkg::carry_t                               carry_i,
  input  logic [l4lb_pkg::idx_bits(BACKEND_COUNT)-1:0]   key_i,
  input  logic [31:0]                                    ip_i,
  input  logic [47:0]                                    mac_i,
  output l4lb_pkg::out_t                                 out_o
);

  logic [15:0]    chk_n, old_lo_n, old_hi_n;
  logic [18:0]    sum;
  logic [16:0]    fold1;
  logic [15:0]    fold2;
  logic [8:0]     key9;
  l4lb_pkg::out_t out_d, out_q;

  always_comb begin
    chk_n    = ~carry_i.ip_checksum;
    old_lo_n = ~carry_i.address[15:0];
    old_hi_n = ~carry_i.address[31:16];
    sum = {3'b0, chk_n} + {3'b0, old_lo_n} + {3'b0, old_hi_n}
        + {3'b0, ip_i[15:0]} + {3'b0, ip_i[31:16]};
    // two end-around carry folds
    fold1 = {1'b0, sum[15:0]} + {14'b0, sum[18:16]};
    fold2 = fold1[15:0] + {15'b0, fold1[16]};
    key9  = 9'(key_i);

    if (carry_i.ok) begin
      out_d.verdict       = peer_set_i ? l4lb_pkg::VERDICT_REDIRECT
                                       : l4lb_pkg::VERDICT_REWRITE;
      out_d.backend_index = key9[1:0];
      out_d.new_address   = ip_i;
      out_d.new_checksum  = ~fold2;
      out_d.new_mac       = mac_i;
    end else begin
      out_d.verdict       = l4lb_pkg::VERDICT_PASS;
      out_d.backend_index = 2'd0;
      out_d.new_address   = carry_i.address;
      out_d.new_checksum  = carry_i.ip_checksum;
      out_d.new_mac       = 48'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s7) begin
      out_q <= out_d;
    end
  end

  assign out_o = out_q;

endmodule
